>>> hdl/sdpq_pkg.sv
`timescale 1ns / 1ps

package sdpq_pkg;

    // field widths fixed by the note format
    localparam int LEN_W     = 4;
    localparam int TONIC_W   = 4;
    localparam int PCLASS_W  = 4;
    localparam int DEGREE_W  = 8;
    localparam int ACC_W     = 5;
    localparam int OCT_W     = 5;
    localparam int OFFS_W    = 4;
    localparam int TRSEMI_W  = 10;
    localparam int TROCT_W   = 7;
    localparam int OUT_W     = 13;
    localparam int CFG_W     = 60;
    localparam int CFG_IDX_W = 2;

    // internal arithmetic widths
    localparam int Z_W       = 10;   // degree - 1 + shift
    localparam int CHR_W     = 12;   // sum of the chromatic transposes
    localparam int BASE_W    = 14;   // everything except the scale octave and interval
    localparam int SUM_W     = 15;   // full pitch before clamping

    // floor division: dividend biased by DIV_OFFSET * len so it is never negative
    localparam int DIV_W        = 12;
    localparam int DIV_STEPS    = 4;  // quotient bits per pipeline stage
    localparam int DIV_STAGES   = DIV_W / DIV_STEPS;
    localparam int DIV_OFF_SH   = 8;
    localparam int DIV_OFFSET   = (1 << DIV_OFF_SH) + 1;

    localparam int MIDI_MIDDLE_C = 60;
    localparam int OUT_MAX       = (1 << (OUT_W - 1)) - 1;
    localparam int OUT_MIN       = -(1 << (OUT_W - 1));

    // register index map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TONIC     = 2'd0,
        CFG_SCALE_LEN = 2'd1,
        CFG_INTERVALS = 2'd2
    } cfg_index_t;

    // one note as it arrives
    typedef struct packed {
        logic                        absolute_mode;
        logic signed [DEGREE_W-1:0]  degree;
        logic signed [ACC_W-1:0]     accidental;
        logic [PCLASS_W-1:0]         pitch_class;
        logic                        has_own_octave;
        logic signed [OCT_W-1:0]     note_octave;
        logic signed [OFFS_W-1:0]    octave_offset;
        logic signed [OCT_W-1:0]     sequence_octave;
        logic signed [DEGREE_W-1:0]  degree_shift;
        logic signed [TRSEMI_W-1:0]  degree_transpose_semis;
        logic signed [TRSEMI_W-1:0]  semitone_transpose;
        logic signed [TROCT_W-1:0]   octave_transpose;
    } note_t;

    // work in flight through the divider
    typedef struct packed {
        logic [DIV_W-1:0]          num;   // dividend bits, quotient shifts in from the bottom
        logic [LEN_W-1:0]          rem;
        logic [LEN_W-1:0]          len;
        logic signed [BASE_W-1:0]  base;
        logic                      abs_mode;
        logic                      empty;
    } div_t;

    // after quotient and interval have been added
    typedef struct packed {
        logic signed [SUM_W-1:0]   sum;
        logic                      empty;
    } sum_t;

endpackage

>>> hdl/sdpq_front.sv
`timescale 1ns / 1ps

module sdpq_front #(
    parameter int MAX_SCALE_LENGTH = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  sdpq_pkg::note_t                   in_note,
    input  logic [sdpq_pkg::TONIC_W-1:0]      tonic_semitone,
    input  logic [sdpq_pkg::LEN_W-1:0]        scale_length,
    output logic                              out_valid,
    input  logic                              out_ready,
    output sdpq_pkg::div_t                    out_data
);

    localparam int LEN_W   = sdpq_pkg::LEN_W;
    localparam int Z_W     = sdpq_pkg::Z_W;
    localparam int CHR_W   = sdpq_pkg::CHR_W;
    localparam int BASE_W  = sdpq_pkg::BASE_W;
    localparam int DIV_W   = sdpq_pkg::DIV_W;
    localparam int OCTS_W  = sdpq_pkg::OCT_W + 1;
    localparam int SH      = sdpq_pkg::DIV_OFF_SH;

    logic                      valid_reg;
    logic                      valid_next;
    sdpq_pkg::div_t            data_reg;
    sdpq_pkg::div_t            data_next;
    logic                      load;

    logic [LEN_W-1:0]          len_eff;
    logic signed [Z_W-1:0]     z;
    logic [DIV_W:0]            len_scaled;
    logic [DIV_W:0]            biased;
    logic signed [CHR_W-1:0]   chrom;
    logic signed [OCTS_W-1:0]  octave;
    logic signed [BASE_W-1:0]  root;
    logic signed [BASE_W-1:0]  extra;

    assign load     = !valid_reg || out_ready;
    assign in_ready = load;

    // scale length clamp and biased dividend
    always_comb begin
        if (scale_length > LEN_W'(MAX_SCALE_LENGTH)) begin
            len_eff = LEN_W'(MAX_SCALE_LENGTH);
        end else begin
            len_eff = scale_length;
        end
        z = Z_W'(in_note.degree) + Z_W'(in_note.degree_shift) - 10'sd1;
        len_scaled = {{(DIV_W + 1 - LEN_W - SH){1'b0}}, len_eff, {SH{1'b0}}}
                   + (DIV_W + 1)'(len_eff);
        biased = (DIV_W + 1)'(z) + len_scaled;
    end

    // octave root, transposes and the mode dependent offset
    always_comb begin
        chrom = CHR_W'(in_note.degree_transpose_semis)
              + CHR_W'(in_note.semitone_transpose)
              + (CHR_W'(in_note.octave_transpose) <<< 3)
              + (CHR_W'(in_note.octave_transpose) <<< 2);
        if (in_note.has_own_octave) begin
            octave = OCTS_W'(in_note.note_octave);
        end else begin
            octave = OCTS_W'(in_note.sequence_octave);
        end
        octave = octave + OCTS_W'(in_note.octave_offset) + 6'sd1;
        root = (BASE_W'(octave) <<< 3) + (BASE_W'(octave) <<< 2);
        if (in_note.absolute_mode) begin
            extra = BASE_W'($signed({1'b0, in_note.pitch_class}));
        end else begin
            extra = BASE_W'($signed({1'b0, tonic_semitone}))
                  + BASE_W'(in_note.accidental);
        end
    end

    always_comb begin
        data_next.num      = biased[DIV_W-1:0];
        data_next.rem      = '0;
        data_next.len      = len_eff;
        data_next.base     = root + BASE_W'(chrom) + extra
                           - BASE_W'(sdpq_pkg::MIDI_MIDDLE_C);
        data_next.abs_mode = in_note.absolute_mode;
        data_next.empty    = !in_note.absolute_mode && (len_eff == '0);
        valid_next         = load ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hdl/sdpq_div.sv
`timescale 1ns / 1ps

module sdpq_div (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  sdpq_pkg::div_t   in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output sdpq_pkg::div_t   out_data
);

    localparam int STAGES = sdpq_pkg::DIV_STAGES;
    localparam int STEPS  = sdpq_pkg::DIV_STEPS;
    localparam int LEN_W  = sdpq_pkg::LEN_W;
    localparam int DIV_W  = sdpq_pkg::DIV_W;

    logic [STAGES-1:0]   valid_reg;
    logic [STAGES-1:0]   valid_next;
    logic [STAGES-1:0]   load;
    logic [STAGES:0]     ready_chain;
    logic [STAGES:0]     valid_chain;
    sdpq_pkg::div_t      data_reg   [STAGES];
    sdpq_pkg::div_t      data_next  [STAGES];
    sdpq_pkg::div_t      data_chain [STAGES+1];

    assign valid_chain[0]      = in_valid;
    assign data_chain[0]       = in_data;
    assign ready_chain[STAGES] = out_ready;
    assign in_ready            = ready_chain[0];

    genvar g;
    generate
        for (g = 0; g < STAGES; g++) begin : g_stage
            assign load[g]           = !valid_reg[g] || ready_chain[g+1];
            assign ready_chain[g]    = load[g];
            assign valid_chain[g+1]  = valid_reg[g];
            assign data_chain[g+1]   = data_reg[g];

            // restoring division, STEPS quotient bits in this stage
            always_comb begin
                logic [LEN_W:0] part;
                logic           qbit;
                data_next[g] = data_chain[g];
                for (int s = 0; s < STEPS; s++) begin
                    part = {data_next[g].rem, data_next[g].num[DIV_W-1]};
                    qbit = (part >= {1'b0, data_next[g].len});
                    if (qbit) begin
                        part = part - {1'b0, data_next[g].len};
                    end
                    data_next[g].rem = part[LEN_W-1:0];
                    data_next[g].num = {data_next[g].num[DIV_W-2:0], qbit};
                end
                valid_next[g] = load[g] ? valid_chain[g] : valid_reg[g];
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[g] <= 1'b0;
                end else begin
                    valid_reg[g] <= valid_next[g];
                end
            end

            always_ff @(posedge aclk) begin
                if (load[g] && valid_chain[g]) begin
                    data_reg[g] <= data_next[g];
                end
            end
        end
    endgenerate

    assign out_valid = valid_chain[STAGES];
    assign out_data  = data_chain[STAGES];

endmodule

>>> hdl/sdpq_back.sv
`timescale 1ns / 1ps

module sdpq_back #(
    parameter int MAX_SCALE_LENGTH = 12,
    parameter int INTERVAL_BITS    = 5
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  sdpq_pkg::div_t                                in_data,
    input  logic [MAX_SCALE_LENGTH*INTERVAL_BITS-1:0]     interval_table,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic signed [sdpq_pkg::OUT_W-1:0]             out_pitch,
    output logic                                          out_saturated
);

    localparam int LEN_W  = sdpq_pkg::LEN_W;
    localparam int DIV_W  = sdpq_pkg::DIV_W;
    localparam int SUM_W  = sdpq_pkg::SUM_W;
    localparam int OUT_W  = sdpq_pkg::OUT_W;
    localparam int Q_W    = DIV_W + 1;

    logic                    sum_valid_reg;
    logic                    sum_valid_next;
    sdpq_pkg::sum_t          sum_reg;
    sdpq_pkg::sum_t          sum_next;
    logic                    sum_load;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic signed [OUT_W-1:0] pitch_reg;
    logic signed [OUT_W-1:0] pitch_next;
    logic                    sat_reg;
    logic                    sat_next;
    logic                    out_load;

    logic signed [Q_W-1:0]     octs;
    logic signed [SUM_W-1:0]   octs_semis;
    logic [INTERVAL_BITS-1:0]  interval;

    assign out_load = !out_valid_reg || out_ready;
    assign sum_load = !sum_valid_reg || out_load;
    assign in_ready = sum_load;

    // interval lookup by the division remainder
    always_comb begin
        interval = '0;
        for (int i = 0; i < MAX_SCALE_LENGTH; i++) begin
            if (in_data.rem == LEN_W'(i)) begin
                interval = interval_table[i*INTERVAL_BITS +: INTERVAL_BITS];
            end
        end
    end

    // remove the division bias, twelve semitones per scale octave
    always_comb begin
        octs       = $signed({1'b0, in_data.num}) - Q_W'(sdpq_pkg::DIV_OFFSET);
        octs_semis = (SUM_W'(octs) <<< 3) + (SUM_W'(octs) <<< 2);
        if (in_data.abs_mode) begin
            sum_next.sum = SUM_W'(in_data.base);
        end else begin
            sum_next.sum = SUM_W'(in_data.base) + octs_semis
                         + SUM_W'($signed({1'b0, interval}));
        end
        sum_next.empty = in_data.empty;
        sum_valid_next = sum_load ? in_valid : sum_valid_reg;
    end

    // clamp to the output range
    always_comb begin
        priority if (sum_reg.empty) begin
            pitch_next = '0;
            sat_next   = 1'b0;
        end else if (sum_reg.sum > SUM_W'(sdpq_pkg::OUT_MAX)) begin
            pitch_next = OUT_W'(sdpq_pkg::OUT_MAX);
            sat_next   = 1'b1;
        end else if (sum_reg.sum < SUM_W'(sdpq_pkg::OUT_MIN)) begin
            pitch_next = OUT_W'(sdpq_pkg::OUT_MIN);
            sat_next   = 1'b1;
        end else begin
            pitch_next = sum_reg.sum[OUT_W-1:0];
            sat_next   = 1'b0;
        end
        out_valid_next = out_load ? sum_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            sum_valid_reg <= sum_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_load && in_valid) begin
            sum_reg <= sum_next;
        end
        if (out_load && sum_valid_reg) begin
            pitch_reg <= pitch_next;
            sat_reg   <= sat_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_pitch     = pitch_reg;
    assign out_saturated = sat_reg;

endmodule

>>> hdl/scale_degree_pitch_quantizer.sv
`timescale 1ns / 1ps

// Scale degree pitch quantizer: turns one note description per transaction into a pitch in
// whole semitones relative to MIDI note 60 (divide by twelve for volts), either from a pitch
// class (absolute mode) or from a one-based scale degree split by floor division over the
// configured scale length. Results outside -4096..4095 are clamped and flagged in m_tuser.
// It takes one note per clock unless the output stalls; a note passes registers for offset
// arithmetic, a four-bit-per-stage restoring divider for the degree split, interval lookup
// and accumulation, and clamping into the output register. Each stage holds its own valid
// bit, so bubbles are absorbed under back pressure. Registers are written through
// cfg_we/cfg_index/cfg_wdata by the user only while no note is in flight (not enforced).
module scale_degree_pitch_quantizer #(
    parameter int MAX_SCALE_LENGTH = 12,
    parameter int INTERVAL_BITS    = 5
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // note input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // degree, accidental, pitch_class, note_octave, octave_offset, sequence_octave,
    // degree_shift, degree_transpose_semis, semitone_transpose, octave_transpose, zero pad
    input  logic [71:0]                       s_tdata,
    // absolute_mode, has_own_octave
    input  logic [1:0]                        s_tuser,
    // pitch output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pitch_semitones, zero pad
    output logic [15:0]                       m_tdata,
    // saturated
    output logic                              m_tuser,
    // register writes
    input  logic                              cfg_we,
    input  logic [sdpq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sdpq_pkg::CFG_W-1:0]        cfg_wdata
);

    localparam int TAB_W  = MAX_SCALE_LENGTH * INTERVAL_BITS;
    localparam int OUT_W  = sdpq_pkg::OUT_W;
    localparam int LEN_W  = sdpq_pkg::LEN_W;
    localparam int TON_W  = sdpq_pkg::TONIC_W;

    logic [TON_W-1:0]          tonic_reg;
    logic [LEN_W-1:0]          scale_len_reg;
    logic [TAB_W-1:0]          table_reg;

    sdpq_pkg::note_t           note;
    logic                      front_valid;
    logic                      front_ready;
    sdpq_pkg::div_t            front_data;
    logic                      div_valid;
    logic                      div_ready;
    sdpq_pkg::div_t            div_data;
    logic signed [OUT_W-1:0]   pitch;
    logic                      saturated;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tonic_reg     <= '0;
            scale_len_reg <= LEN_W'(7);
            table_reg     <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                sdpq_pkg::CFG_TONIC:     tonic_reg     <= cfg_wdata[TON_W-1:0];
                sdpq_pkg::CFG_SCALE_LEN: scale_len_reg <= cfg_wdata[LEN_W-1:0];
                sdpq_pkg::CFG_INTERVALS: table_reg     <= cfg_wdata[TAB_W-1:0];
                default: ;
            endcase
        end
    end

    // unpack the note transaction
    always_comb begin
        note.absolute_mode          = s_tuser[0];
        note.has_own_octave         = s_tuser[1];
        note.degree                 = s_tdata[7:0];
        note.accidental             = s_tdata[12:8];
        note.pitch_class            = s_tdata[16:13];
        note.note_octave            = s_tdata[21:17];
        note.octave_offset          = s_tdata[25:22];
        note.sequence_octave        = s_tdata[30:26];
        note.degree_shift           = s_tdata[38:31];
        note.degree_transpose_semis = s_tdata[48:39];
        note.semitone_transpose     = s_tdata[58:49];
        note.octave_transpose       = s_tdata[65:59];
    end

    sdpq_front #(
        .MAX_SCALE_LENGTH (MAX_SCALE_LENGTH)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_note        (note),
        .tonic_semitone (tonic_reg),
        .scale_length   (scale_len_reg),
        .out_valid      (front_valid),
        .out_ready      (front_ready),
        .out_data       (front_data)
    );

    sdpq_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    sdpq_back #(
        .MAX_SCALE_LENGTH (MAX_SCALE_LENGTH),
        .INTERVAL_BITS    (INTERVAL_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (div_valid),
        .in_ready       (div_ready),
        .in_data        (div_data),
        .interval_table (table_reg),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_pitch      (pitch),
        .out_saturated  (saturated)
    );

    assign m_tdata = {{(16 - OUT_W){1'b0}}, pitch};
    assign m_tuser = saturated;

endmodule

>>> hdl/sdpq_checker.sv
`timescale 1ns / 1ps

module sdpq_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tuser
);

    localparam int DEPTH = 6;

    logic [3:0] inflight_reg;
    logic [3:0] inflight_next;

    // notes accepted but not yet delivered
    always_comb begin
        inflight_next = inflight_reg;
        if (s_tvalid && s_tready) begin
            inflight_next = inflight_next + 4'd1;
        end
        if (m_tvalid && m_tready) begin
            inflight_next = inflight_next - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    // no result without a note behind it
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> inflight_reg != 4'd0)
        else $error("result shown with no note in flight");

    // pipeline never holds more notes than it has stages
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= 4'(DEPTH))
        else $error("more notes in flight than pipeline stages");

    // a clamped result sits exactly on a range limit
    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 16'h0FFF || m_tdata == 16'h1000)
        else $error("saturated flag with value off the range limits");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind scale_degree_pitch_quantizer sdpq_checker u_sdpq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
